// ===== design/cpse_pkg.sv =====
// Shared types and constants for the characteristic polynomial set sketch encoder.
// Used by cpse_cell and charpoly_set_sketch_encoder_top; depends on nothing else.

package cpse_pkg;

  localparam int unsigned MaxTermsDef = 16;
  localparam int unsigned ModulusDef  = 998244353;

  localparam int unsigned CoefW     = 30;
  localparam int unsigned ElemW     = 30;
  localparam int unsigned OpW       = 2;
  localparam int unsigned IdxOutW   = 4;
  localparam int unsigned CountOutW = 6;
  localparam int unsigned NumTermsW = 5;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;

  localparam logic [NumTermsW-1:0] NumTermsRst = 5'd8;

  // Word index of the num_terms register (byte address bit 2).
  localparam logic REG_NUM_TERMS = 1'b0;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMMIT,
    ST_READ,
    ST_CLEAR
  } state_e;

  // Control that the sequencer broadcasts to every cell of the row.
  typedef struct packed {
    logic start;
    logic step;
    logic mbit;
    logic commit;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== design/cpse_cell.sv =====
// One coefficient cell of the sketch row: holds one coefficient and a bit-serial
// modular product accumulator. Depends on cpse_pkg.

module cpse_cell import cpse_pkg::*; #(
  parameter logic [CoefW-1:0] RST_VAL = '0,
  parameter int unsigned      MODULUS = ModulusDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CoefW-1:0] prev_i,
  output logic [CoefW-1:0] coef_o
);

  localparam logic [CoefW+1:0] Mod1 = (CoefW+2)'(MODULUS);
  localparam logic [CoefW+1:0] Mod2 = (CoefW+2)'(2 * MODULUS);

  logic [CoefW-1:0] coef_q, coef_d;
  logic [CoefW-1:0] acc_q, acc_d;
  logic [CoefW+1:0] acc_sum;
  logic [CoefW:0]   diff;

  // Horner step, element bits MSB first: acc = 2*acc + bit*coef, kept below the modulus.
  always_comb begin
    acc_sum = {1'b0, acc_q, 1'b0} + {2'b00, coef_q & {CoefW{ctrl_i.mbit}}};
    if (acc_sum >= Mod2) begin
      acc_d = CoefW'(acc_sum - Mod2);
    end else if (acc_sum >= Mod1) begin
      acc_d = CoefW'(acc_sum - Mod1);
    end else begin
      acc_d = CoefW'(acc_sum);
    end
  end

  // New coefficient is the lower neighbor minus element times this coefficient.
  always_comb begin
    if (prev_i >= acc_q) begin
      diff = {1'b0, prev_i} - {1'b0, acc_q};
    end else begin
      diff = {1'b0, prev_i} + Mod1[CoefW:0] - {1'b0, acc_q};
    end
    coef_d = coef_q;
    if (ctrl_i.clear) begin
      coef_d = RST_VAL;
    end else if (ctrl_i.commit) begin
      coef_d = diff[CoefW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= RST_VAL;
    end else begin
      coef_q <= coef_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= '0;
    end else if (ctrl_i.step) begin
      acc_q <= acc_d;
    end
  end

  assign coef_o = coef_q;

endmodule

// ===== design/charpoly_set_sketch_encoder_top.sv =====
// Top level of the set sketch encoder: sequencer, configuration port and the row
// of coefficient cells. Depends on cpse_pkg and cpse_cell.
//
// Usage: each input transfer carries an op and an element. An insert multiplies the
// sketch by (x - element) modulo MODULUS and returns one result with the new count;
// a zero element (after reduction) leaves the sketch alone and sets bad_element.
// A read returns num_terms results, held to 1..MAX_TERMS, coefficient 0 upward,
// last on the final one. A clear restores the reset sketch and returns one
// all-zero result with last set. Unknown ops are dropped without a result.
// Timing: an insert keeps in_stall_o high through the bit-serial multiply (one
// step per element bit, in every cell at once) and the commit state, so inserts
// do not overlap. A read loads its results in index order and a clear loads its
// one result, each only while the output register is free.
// Results leave through an output register; a new item is taken while a result
// still waits there, and the block holds in its commit, read or clear state while
// out_stall_i keeps that register full. Reset gives num_terms 8, count 0 and the
// sketch polynomial 1; it needs no clearing pass. num_terms is written over the
// APB port at byte address 0, by the user while idle; the block does not enforce it.

module charpoly_set_sketch_encoder_top import cpse_pkg::*; #(
  parameter int unsigned MAX_TERMS = MaxTermsDef,
  parameter int unsigned MODULUS   = ModulusDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Item channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OpW-1:0]       op_i,
  input  logic [ElemW-1:0]     element_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IdxOutW-1:0]   coef_index_o,
  output logic [CoefW-1:0]     coef_value_o,
  output logic [CountOutW-1:0] elem_count_o,
  output logic                 bad_element_o,
  output logic                 last_o,
  // Configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [DataW-1:0]     pwdata,
  output logic [DataW-1:0]     prdata,
  output logic                 pready
);

  localparam int unsigned TermW = $clog2(MAX_TERMS + 1);
  localparam int unsigned CntW  = TermW + 1;
  localparam int unsigned IdxW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned StepW = $clog2(ElemW);
  localparam logic [CoefW:0] ModRed = (CoefW+1)'(MODULUS);

  state_e                 state_q, state_d;
  cell_ctrl_t             ctrl;
  logic [NumTermsW-1:0]   nt_q;
  logic [TermW-1:0]       eff_terms;
  logic [CntW-1:0]        cnt_mod;
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        cnt_work_q;
  logic                   cnt_done;
  logic [IdxW-1:0]        idx_q;
  logic                   read_last;
  logic [StepW-1:0]       step_q;
  logic                   step_last;
  logic [ElemW-1:0]       elem_q;
  logic [CoefW-1:0]       red_q;
  logic [CoefW:0]         red_sum;
  logic                   elem_zero;
  logic                   accept;
  logic                   out_free;
  logic                   out_load;
  logic [CoefW-1:0]       coef_w [MAX_TERMS];

  logic                   out_valid_q;
  logic [IdxW-1:0]        out_idx_d, out_idx_q;
  logic [CoefW-1:0]       out_val_d, out_val_q;
  logic [CntW-1:0]        out_cnt_d, out_cnt_q;
  logic                   out_bad_d, out_bad_q;
  logic                   out_last_d, out_last_q;

  // Configuration register.
  logic cfg_write;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NUM_TERMS);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_NUM_TERMS) ? DataW'(nt_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nt_q <= NumTermsRst;
    end else if (cfg_write) begin
      nt_q <= pwdata[NumTermsW-1:0];
    end
  end

  always_comb begin
    if (nt_q == '0) begin
      eff_terms = TermW'(1);
    end else if (32'(nt_q) > MAX_TERMS) begin
      eff_terms = TermW'(MAX_TERMS);
    end else begin
      eff_terms = TermW'(nt_q);
    end
  end

  assign cnt_mod   = {eff_terms, 1'b1};
  assign cnt_done  = (cnt_work_q < cnt_mod);
  assign read_last = ((TermW'(idx_q) + TermW'(1)) == eff_terms);
  assign step_last = (step_q == StepW'(ElemW - 1));
  assign elem_zero = (red_q == '0);
  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // Row of cells; each takes its lower neighbor's coefficient on commit.
  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    logic [CoefW-1:0] prev;
    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = coef_w[i-1];
    end
    cpse_cell #(
      .RST_VAL ((i == 0) ? CoefW'(1) : CoefW'(0)),
      .MODULUS (MODULUS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (prev),
      .coef_o (coef_w[i])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            OP_INSERT: state_d = ST_MUL;
            OP_READ:   state_d = ST_READ;
            OP_CLEAR:  state_d = ST_CLEAR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        if (step_last) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (cnt_done && out_free) state_d = ST_IDLE;
      end
      ST_READ: begin
        if (out_free && read_last) state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    ctrl       = '0;
    out_load   = 1'b0;
    out_idx_d  = '0;
    out_val_d  = '0;
    out_cnt_d  = '0;
    out_bad_d  = 1'b0;
    out_last_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ctrl.start = accept && (op_i == OP_INSERT);
      end
      ST_MUL: begin
        ctrl.step = 1'b1;
        ctrl.mbit = elem_q[ElemW-1];
      end
      ST_COMMIT: begin
        if (cnt_done && out_free) begin
          out_load    = 1'b1;
          ctrl.commit = !elem_zero;
          out_cnt_d   = elem_zero ? count_q : cnt_work_q;
          out_bad_d   = elem_zero;
          out_last_d  = 1'b1;
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_idx_d  = idx_q;
          out_val_d  = coef_w[idx_q];
          out_cnt_d  = count_q;
          out_last_d = read_last;
        end
      end
      ST_CLEAR: begin
        if (out_free) begin
          out_load   = 1'b1;
          ctrl.clear = 1'b1;
          out_last_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.commit) begin
        count_q <= cnt_work_q;
      end else if (ctrl.clear) begin
        count_q <= '0;
      end
      if (state_q == ST_READ && out_free) begin
        idx_q <= read_last ? '0 : idx_q + IdxW'(1);
      end
      if (ctrl.start) begin
        step_q <= '0;
      end else if (ctrl.step) begin
        step_q <= step_q + StepW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Element residue, reduced one bit per step alongside the cell products.
  assign red_sum = {red_q, elem_q[ElemW-1]};

  always_ff @(posedge clk_i) begin
    if (ctrl.start) begin
      elem_q     <= element_i;
      red_q      <= '0;
      cnt_work_q <= count_q + CntW'(1);
    end else begin
      if (ctrl.step) begin
        elem_q <= {elem_q[ElemW-2:0], 1'b0};
        red_q  <= (red_sum >= ModRed) ? CoefW'(red_sum - ModRed) : CoefW'(red_sum);
      end
      if ((state_q == ST_MUL || state_q == ST_COMMIT) && !cnt_done) begin
        cnt_work_q <= cnt_work_q - cnt_mod;
      end
    end
    if (out_load) begin
      out_idx_q  <= out_idx_d;
      out_val_q  <= out_val_d;
      out_cnt_q  <= out_cnt_d;
      out_bad_q  <= out_bad_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coef_index_o  = IdxOutW'(out_idx_q);
  assign coef_value_o  = out_val_q;
  assign elem_count_o  = CountOutW'(out_cnt_q);
  assign bad_element_o = out_bad_q;
  assign last_o        = out_last_q;

  // A transfer of a known op always starts work that holds off the next one.
  a_stall_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (op_i == OP_INSERT || op_i == OP_READ || op_i == OP_CLEAR) |=> in_stall_o)
    else $error("no stall after an accepted item");

  // A result waiting on a stalled receiver is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten");

  // Read-out never walks past the configured number of terms.
  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> TermW'(idx_q) < eff_terms)
    else $error("read index out of range");

  // A rejected element yields an empty, final result.
  a_bad_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_element_o |-> coef_index_o == '0 && coef_value_o == '0 && last_o)
    else $error("bad element result malformed");

endmodule

// ===== tb/charpoly_set_sketch_encoder_top_tb.sv =====
// Self-checking testbench for the characteristic polynomial set sketch encoder.
// Drives items and APB writes, and predicts every result with its own sketch model.
// Depends on cpse_pkg and charpoly_set_sketch_encoder_top.

`timescale 1ns / 100ps

module charpoly_set_sketch_encoder_top_tb;
  import cpse_pkg::*;

  localparam int unsigned    MaxTerms   = MaxTermsDef;
  localparam longint unsigned Modulus   = ModulusDef;
  localparam logic [OpW-1:0] OpUnused   = 2'd3;
  localparam int unsigned    DrainWait  = 40;
  localparam int unsigned    PhaseItems = 70;

  typedef struct {
    logic [OpW-1:0]   op;
    logic [ElemW-1:0] elem;
  } sketch_item_t;

  typedef struct {
    logic [IdxOutW-1:0]   idx;
    logic [CoefW-1:0]     value;
    logic [CountOutW-1:0] cnt;
    logic                 bad;
    logic                 last;
  } sketch_out_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [OpW-1:0]       op_i = '0;
  logic [ElemW-1:0]     element_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [IdxOutW-1:0]   coef_index_o;
  logic [CoefW-1:0]     coef_value_o;
  logic [CountOutW-1:0] elem_count_o;
  logic                 bad_element_o;
  logic                 last_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrW-1:0]     paddr = '0;
  logic [DataW-1:0]     pwdata = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  charpoly_set_sketch_encoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .element_i     (element_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .coef_index_o  (coef_index_o),
    .coef_value_o  (coef_value_o),
    .elem_count_o  (elem_count_o),
    .bad_element_o (bad_element_o),
    .last_o        (last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Predicted sketch state and configuration.
  logic [CoefW-1:0]     sketch_coef [MaxTerms];
  logic [CountOutW-1:0] sketch_count;
  logic [NumTermsW-1:0] num_terms_cfg;

  sketch_item_t item_q[$];
  sketch_out_t  sketch_q[$];

  int  errors = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  long_hold = 0;
  bit  idle_on = 1'b1;
  bit  item_taken = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void enqueue_result(sketch_out_t r);
    sketch_q = {sketch_q, r};
  endfunction

  function automatic void clear_sketch_model();
    for (int i = 0; i < MaxTerms; i++) sketch_coef[i] = '0;
    sketch_coef[0] = CoefW'(1);
    sketch_count   = '0;
  endfunction

  function automatic int unsigned active_terms();
    if (num_terms_cfg == 0) return 1;
    if (num_terms_cfg > MaxTerms) return MaxTerms;
    return num_terms_cfg;
  endfunction

  // Applies one accepted item to the sketch and queues the results it causes.
  function automatic void sketch_update(logic [OpW-1:0] op, logic [ElemW-1:0] elem);
    longint unsigned a, cur, prev, prod;
    int unsigned     d;
    sketch_out_t     r;
    d = active_terms();
    r.idx   = '0;
    r.value = '0;
    r.bad   = 1'b0;
    r.last  = 1'b1;
    case (op)
      OP_INSERT: begin
        a = longint'(elem) % Modulus;
        if (a == 0) begin
          r.bad = 1'b1;
        end else begin
          prev = 0;
          for (int i = 0; i < MaxTerms; i++) begin
            cur  = sketch_coef[i];
            prod = (a * cur) % Modulus;
            sketch_coef[i] = CoefW'((prev + Modulus - prod) % Modulus);
            prev = cur;
          end
          sketch_count = CountOutW'((longint'(sketch_count) + 1) % (2 * d + 1));
        end
        r.cnt = sketch_count;
        enqueue_result(r);
      end
      OP_READ: begin
        for (int unsigned i = 0; i < d; i++) begin
          r.idx   = IdxOutW'(i);
          r.value = sketch_coef[i];
          r.cnt   = sketch_count;
          r.last  = (i + 1 == d);
          enqueue_result(r);
        end
      end
      OP_CLEAR: begin
        clear_sketch_model();
        r.cnt = '0;
        enqueue_result(r);
      end
      default: ;
    endcase
  endfunction

  // Input acceptance: predict at the edge where the transfer happens.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sketch_update(op_i, element_i);
      item_taken = 1'b1;
    end
  end

  // Item driver.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !item_taken) begin
      // Stalled: hold the payload.
    end else begin
      item_taken = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 7);
        in_valid_i <= 1'b0;
      end else if (item_q.size() != 0) begin
        sketch_item_t it;
        it = item_q.pop_front();
        in_valid_i <= 1'b1;
        op_i       <= it.op;
        element_i  <= it.elem;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver stall.
  always @(negedge clk_i) begin
    if (long_hold != 0) begin
      long_hold--;
      out_stall_i <= 1'b1;
    end else if (out_gap != 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin : result_mon
    sketch_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sketch_q.size() == 0) begin
        flag_mismatch("result with none pending, index", coef_index_o, 0);
      end else begin
        e = sketch_q.pop_front();
        if (coef_index_o !== e.idx) flag_mismatch("coef_index", coef_index_o, e.idx);
        if (coef_value_o !== e.value) flag_mismatch("coef_value", coef_value_o, e.value);
        if (elem_count_o !== e.cnt) flag_mismatch("elem_count", elem_count_o, e.cnt);
        if (bad_element_o !== e.bad) flag_mismatch("bad_element", bad_element_o, e.bad);
        if (last_o !== e.last) flag_mismatch("last", last_o, e.last);
      end
    end
  end

  task automatic wait_drained();
    while (item_q.size() != 0 || in_valid_i || sketch_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Writes num_terms over APB and reads it back.
  task automatic write_num_terms(logic [NumTermsW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({REG_NUM_TERMS, 2'b00});
    pwdata  <= DataW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    num_terms_cfg = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DataW'(val)) flag_mismatch("num_terms readback", prdata, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void add_item(logic [OpW-1:0] op, logic [ElemW-1:0] elem);
    sketch_item_t it;
    it.op   = op;
    it.elem = elem;
    item_q = {item_q, it};
  endfunction

  function automatic logic [ElemW-1:0] rand_element();
    int unsigned s;
    s = $urandom_range(0, 19);
    case (s)
      0:       return '0;
      1:       return ElemW'(Modulus);
      2:       return ElemW'($urandom);
      3:       return ElemW'(Modulus + $urandom_range(0, 75497470));
      default: return ElemW'($urandom_range(1, Modulus - 1));
    endcase
  endfunction

  // Mostly inserts so the polynomial gets deep; unused ops do not count.
  task automatic push_random(int n);
    int          made;
    int unsigned r;
    logic [OpW-1:0] op;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 70)      op = OP_INSERT;
      else if (r < 86) op = OP_READ;
      else if (r < 92) op = OP_CLEAR;
      else if (r < 95) op = OpUnused;
      else             op = OP_INSERT;
      add_item(op, rand_element());
      if (op != OpUnused) made++;
    end
  endtask

  initial begin
    logic [NumTermsW-1:0] settings [6];
    num_terms_cfg = NumTermsRst;
    clear_sketch_model();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset setting of eight terms.
    add_item(OP_READ, '0);
    add_item(OP_INSERT, ElemW'(1));
    add_item(OP_INSERT, ElemW'(Modulus - 1));
    add_item(OP_INSERT, '0);
    add_item(OP_INSERT, ElemW'(Modulus));
    add_item(OP_INSERT, '1);
    add_item(OP_INSERT, 30'h2AAAAAAA);
    add_item(OP_INSERT, 30'h15555555);
    add_item(OP_READ, '1);
    add_item(OpUnused, 30'h12345);
    add_item(OP_CLEAR, '1);
    add_item(OP_READ, '0);
    add_item(OP_INSERT, ElemW'(5));
    add_item(OP_READ, '0);
    wait_drained();

    settings[0] = 5'd16;
    settings[1] = 5'd1;
    settings[2] = 5'd0;
    settings[3] = 5'd31;
    settings[4] = NumTermsW'($urandom_range(2, 15));
    settings[5] = 5'd8;
    for (int ph = 0; ph < 6; ph++) begin
      write_num_terms(settings[ph]);
      if (ph == 5) idle_on = 1'b0;
      if (ph == 2) begin
        // Halfway through, the sender waits until every pending result has come out.
        push_random(PhaseItems / 2);
        wait_drained();
        push_random(PhaseItems - PhaseItems / 2);
      end else begin
        push_random(PhaseItems);
      end
      if (ph == 0) begin
        // A long receiver hold while items keep coming fills the block.
        repeat (30) @(posedge clk_i);
        long_hold = 300;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cpse_pkg.sv
design/cpse_cell.sv
design/charpoly_set_sketch_encoder_top.sv
tb/charpoly_set_sketch_encoder_top_tb.sv
